>>> hdl/i2cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cst_pkg
// shared types, constants and helpers of the i2c slave transmitter
// ----------------------------------------------------------------------------
package i2cst_pkg;

    // bytes held in the transmit word, 1 to 4
    localparam int BYTES        = 4;
    localparam int IDX_W        = 3;
    localparam int WORD_W       = 32;
    localparam int ADDR_W       = 7;
    localparam int CFG_INDEX_W  = 4;

    localparam logic [IDX_W-1:0] BYTES_IDX = IDX_W'(BYTES);

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TX_WORD     = CFG_INDEX_W'(1);

    // reset values
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = 7'h48;
    localparam logic [WORD_W-1:0] TX_WORD_RST     = '0;

    // shift unit codes
    localparam logic [7:0] ACK_BYTE   = 8'h00;
    localparam logic [7:0] NACK_BYTE  = 8'hFF;
    localparam logic [3:0] CNT_NONE   = 4'd0;
    localparam logic [3:0] CNT_ACK    = 4'd1;
    localparam logic [3:0] CNT_BYTE   = 4'd8;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [WORD_W-1:0]      data;
    } cfg_wr_t;

    typedef struct packed {
        logic       load_shift;
        logic [7:0] shift_value;
        logic [3:0] bit_count;
        logic       sda_drive;
        logic       clear_start;
    } result_t;

    // byte k of the word, byte zero at the most significant end
    function automatic logic [7:0] byte_of(input logic [WORD_W-1:0] word,
                                           input logic [1:0] k);
        logic [WORD_W-1:0] sh;
        sh = word >> {2'd3 - k, 3'b000};
        return sh[7:0];
    endfunction

endpackage

>>> hdl/i2cst_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cst_fsm
// transfer sequencer: phase, byte index, expected address, line drive
// ----------------------------------------------------------------------------
module i2cst_fsm
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     start_seen,
    input  logic [7:0]               shift_byte,
    input  i2cst_pkg::cfg_wr_t       cfg,
    output i2cst_pkg::result_t       result
);

    typedef enum logic [2:0]
    {
        PH_IDLE     = 3'd0,
        PH_ADDRESS  = 3'd1,
        PH_PROCADDR = 3'd2,
        PH_RXCHECK  = 3'd3,
        PH_TXDATA   = 3'd4,
        PH_ACKNACK  = 3'd5,
        PH_TXCHECK  = 3'd6
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic [i2cst_pkg::IDX_W-1:0]      byte_index_reg, byte_index_next;
    logic [7:0]                       exp_addr_reg, exp_addr_next;
    logic                             drive_reg, drive_next;
    logic [i2cst_pkg::ADDR_W-1:0]     own_addr_reg, own_addr_next;
    logic [i2cst_pkg::WORD_W-1:0]     tx_word_reg, tx_word_next;

    always_comb
    begin
        phase_t                        ph;
        logic [i2cst_pkg::IDX_W-1:0]   send_idx;
        logic [7:0]                    send_val;
        logic [7:0]                    exp_inc;

        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        exp_addr_next   = exp_addr_reg;
        drive_next      = drive_reg;
        own_addr_next   = own_addr_reg;
        tx_word_next    = tx_word_reg;

        result.load_shift  = 1'b0;
        result.shift_value = i2cst_pkg::ACK_BYTE;
        result.bit_count   = i2cst_pkg::CNT_NONE;
        result.clear_start = 1'b0;

        ph       = start_seen ? PH_ADDRESS : phase_reg;
        // index past the end wraps to byte zero
        send_idx = (byte_index_reg >= i2cst_pkg::BYTES_IDX) ? '0 : byte_index_reg;
        send_val = i2cst_pkg::byte_of(tx_word_reg, send_idx[1:0]);
        exp_inc  = shift_byte[0] ? exp_addr_reg + 8'd1 : exp_addr_reg;

        if (step)
        begin
            case (ph)
                PH_ADDRESS:
                begin
                    result.bit_count   = i2cst_pkg::CNT_BYTE;
                    result.clear_start = 1'b1;
                    phase_next         = PH_PROCADDR;
                end
                PH_PROCADDR:
                begin
                    exp_addr_next     = exp_inc;
                    drive_next        = 1'b1;
                    result.load_shift = 1'b1;
                    result.bit_count  = i2cst_pkg::CNT_ACK;
                    if (shift_byte == exp_inc)
                    begin
                        result.shift_value = i2cst_pkg::ACK_BYTE;
                        phase_next         = PH_TXDATA;
                    end
                    else
                    begin
                        result.shift_value = i2cst_pkg::NACK_BYTE;
                        phase_next         = PH_RXCHECK;
                    end
                end
                PH_RXCHECK:
                begin
                    // back to idle, byte index kept
                    drive_next    = 1'b0;
                    exp_addr_next = {own_addr_reg, 1'b0};
                    phase_next    = PH_IDLE;
                end
                PH_ACKNACK:
                begin
                    drive_next       = 1'b0;
                    result.bit_count = i2cst_pkg::CNT_ACK;
                    phase_next       = PH_TXCHECK;
                end
                PH_TXDATA, PH_TXCHECK:
                begin
                    if (ph == PH_TXCHECK &&
                        (shift_byte[0] || byte_index_reg >= i2cst_pkg::BYTES_IDX))
                    begin
                        // master nack or out of bytes
                        drive_next      = 1'b0;
                        exp_addr_next   = {own_addr_reg, 1'b0};
                        byte_index_next = '0;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        drive_next         = 1'b1;
                        result.load_shift  = 1'b1;
                        result.shift_value = send_val;
                        result.bit_count   = i2cst_pkg::CNT_BYTE;
                        byte_index_next    = send_idx + 3'd1;
                        phase_next         = PH_ACKNACK;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        result.sda_drive = drive_next;

        if (cfg.valid)
        begin
            case (cfg.index)
                i2cst_pkg::REG_OWN_ADDRESS:
                begin
                    own_addr_next = cfg.data[i2cst_pkg::ADDR_W-1:0];
                    exp_addr_next = {cfg.data[i2cst_pkg::ADDR_W-1:0], 1'b0};
                end
                i2cst_pkg::REG_TX_WORD:
                begin
                    tx_word_next = cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_index_reg <= '0;
            exp_addr_reg   <= {i2cst_pkg::OWN_ADDRESS_RST, 1'b0};
            drive_reg      <= 1'b0;
            own_addr_reg   <= i2cst_pkg::OWN_ADDRESS_RST;
            tx_word_reg    <= i2cst_pkg::TX_WORD_RST;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            exp_addr_reg   <= exp_addr_next;
            drive_reg      <= drive_next;
            own_addr_reg   <= own_addr_next;
            tx_word_reg    <= tx_word_next;
        end
    end

    // the line is driven while a data byte is due or being shifted
    a_drive_in_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TXDATA || phase_reg == PH_ACKNACK) |-> drive_reg)
        else $error("line released during transmit");

    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> !drive_reg)
        else $error("line driven while idle");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= i2cst_pkg::BYTES_IDX)
        else $error("byte index beyond end");

endmodule

>>> hdl/i2c_slave_transmitter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_transmitter_unit
// transmit-only i2c slave sequencer, one shift-unit event in, one command out
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  event    | in        | in_valid/in_stall  | start_seen, shift_byte
//  command  | out       | out_valid/out_stall| load_shift, shift_value,
//           |           |                    | bit_count, sda_drive, clear_start
//  config   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one beat per clock while the command side is not stalled; a beat goes
//  event register -> sequencer -> command register, with the sequencer
//  combinational between the two registers
//  the sequencer state advances once for each event beat passed on
//  reset clears the valid flags and puts the sequencer idle with the
//  address and transmit word at their reset values
//  a stalled command holds and only stalls the event side when the
//  event register is also full; config writes are always taken
//
module i2c_slave_transmitter_unit
(
    input  logic                              clk,
    input  logic                              rst_n,

    // event channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              start_seen,
    input  logic [7:0]                        shift_byte,

    // command channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              load_shift,
    output logic [7:0]                        shift_value,
    output logic [3:0]                        bit_count,
    output logic                              sda_drive,
    output logic                              clear_start,

    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [i2cst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cst_pkg::WORD_W-1:0]      cfg_data
);

    // event register
    logic                 in_valid_reg, in_valid_next;
    logic                 start_reg;
    logic [7:0]           byte_reg;

    // command register
    logic                 out_valid_reg, out_valid_next;
    i2cst_pkg::result_t   res_reg;
    i2cst_pkg::result_t   res_next;

    i2cst_pkg::cfg_wr_t   cfg;
    logic                 advance;
    logic                 step;
    logic                 in_take;

    // the command register frees when empty or taken this edge
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    i2cst_fsm u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .start_seen (start_reg),
        .shift_byte (byte_reg),
        .cfg        (cfg),
        .result     (res_next)
    );

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        out_valid_next = step ? 1'b1 : (advance ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            start_reg <= start_seen;
            byte_reg  <= shift_byte;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign load_shift  = res_reg.load_shift;
    assign shift_value = res_reg.shift_value;
    assign bit_count   = res_reg.bit_count;
    assign sda_drive   = res_reg.sda_drive;
    assign clear_start = res_reg.clear_start;

    // no byte is shown unless it is to be loaded
    a_value_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !load_shift) |-> (shift_value == i2cst_pkg::ACK_BYTE))
        else $error("shift value without load");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && load_shift) |->
        (bit_count == i2cst_pkg::CNT_ACK || bit_count == i2cst_pkg::CNT_BYTE))
        else $error("load with odd bit count");

    a_clear_is_address: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clear_start) |->
        (!load_shift && bit_count == i2cst_pkg::CNT_BYTE))
        else $error("start cleared outside address receive");

    a_stall_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("event side stalled with room to spare");

endmodule

>>> bench/i2c_slave_transmitter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_transmitter_unit_test
// self-checking bench: a directed stimulus table, then constrained-by-hand
// random address/data sequences under several register settings; every
// command is checked field by field against a typed row or the sequencer model
// ----------------------------------------------------------------------------
module i2c_slave_transmitter_unit_test;

    localparam int CYCLE_LIMIT     = 500_000;
    localparam int RANDOM_SETTINGS = 8;
    localparam int EVENTS_PER_SET  = 160;
    localparam int SETTLE_CYCLES   = 4;

    // first index past the register list, writes there are dropped
    localparam logic [i2cst_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO =
        i2cst_pkg::REG_TX_WORD + 4'd1;
    localparam logic [i2cst_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = '1;

    // sequencer phases, mirrored from the block's behaviour
    typedef enum logic [2:0] {
        SEQ_IDLE       = 3'd0,
        SEQ_ADDRESS    = 3'd1,
        SEQ_ADDR_CHECK = 3'd2,
        SEQ_NACK_DONE  = 3'd3,
        SEQ_TX_DATA    = 3'd4,
        SEQ_ACK_WAIT   = 3'd5,
        SEQ_TX_CHECK   = 3'd6
    } seq_phase_t;

    // one row of the directed table; want is only used when typed is set
    typedef struct packed {
        logic                 start;
        logic [7:0]           sb;
        logic                 typed;
        i2cst_pkg::result_t   want;
    } stim_row_t;

    // transmit word of the directed part, both byte extremes inside
    localparam logic [i2cst_pkg::WORD_W-1:0] DIR_WORD = 32'hFF00_A55A;

    localparam i2cst_pkg::result_t RES_QUIET     =
        {1'b0, 8'h00, i2cst_pkg::CNT_NONE, 1'b0, 1'b0};
    localparam i2cst_pkg::result_t RES_START     =
        {1'b0, 8'h00, i2cst_pkg::CNT_BYTE, 1'b0, 1'b1};
    localparam i2cst_pkg::result_t RES_ADDR_ACK  =
        {1'b1, i2cst_pkg::ACK_BYTE, i2cst_pkg::CNT_ACK, 1'b1, 1'b0};
    localparam i2cst_pkg::result_t RES_ADDR_NACK =
        {1'b1, i2cst_pkg::NACK_BYTE, i2cst_pkg::CNT_ACK, 1'b1, 1'b0};
    localparam i2cst_pkg::result_t RES_ACK_SLOT  =
        {1'b0, 8'h00, i2cst_pkg::CNT_ACK, 1'b0, 1'b0};
    localparam i2cst_pkg::result_t RES_BYTE0     =
        {1'b1, DIR_WORD[31:24], i2cst_pkg::CNT_BYTE, 1'b1, 1'b0};
    localparam i2cst_pkg::result_t RES_BYTE1     =
        {1'b1, DIR_WORD[23:16], i2cst_pkg::CNT_BYTE, 1'b1, 1'b0};
    localparam i2cst_pkg::result_t RES_BYTE2     =
        {1'b1, DIR_WORD[15:8], i2cst_pkg::CNT_BYTE, 1'b1, 1'b0};
    localparam i2cst_pkg::result_t RES_BYTE3     =
        {1'b1, DIR_WORD[7:0], i2cst_pkg::CNT_BYTE, 1'b1, 1'b0};

    // runs with the reset address 72, so a read addresses 0x91
    localparam int N_DIRECTED = 26;
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        {1'b0, 8'hFF, 1'b1, RES_QUIET},      // idle beat without start
        {1'b1, 8'h00, 1'b1, RES_START},
        {1'b0, 8'h91, 1'b1, RES_ADDR_ACK},   // read bit bumps 0x90 to 0x91
        {1'b0, 8'h00, 1'b1, RES_BYTE0},
        {1'b0, 8'hAB, 1'b1, RES_ACK_SLOT},   // byte ignored in the ack slot
        {1'b0, 8'h00, 1'b1, RES_BYTE1},
        {1'b0, 8'h7E, 1'b1, RES_ACK_SLOT},
        {1'b0, 8'hFE, 1'b1, RES_BYTE2},      // only bit 0 is the master ack
        {1'b0, 8'h00, 1'b1, RES_ACK_SLOT},
        {1'b0, 8'h00, 1'b1, RES_BYTE3},
        {1'b0, 8'h55, 1'b1, RES_ACK_SLOT},
        {1'b1, 8'hFF, 1'b1, RES_START},      // restart mid transfer
        {1'b0, 8'h91, 1'b1, RES_ADDR_NACK},  // kept address bumped again
        {1'b0, 8'h80, 1'b1, RES_QUIET},      // nack done, back to idle
        {1'b1, 8'h00, 1'b1, RES_START},
        {1'b0, 8'h91, 1'b1, RES_ADDR_ACK},
        {1'b0, 8'h00, 1'b1, RES_BYTE0},      // index past the end wraps
        {1'b0, 8'h00, 1'b1, RES_ACK_SLOT},
        {1'b0, 8'h01, 1'b1, RES_QUIET},      // master nack ends the read
        {1'b0, 8'h01, 1'b1, RES_QUIET},
        {1'b1, 8'hFF, 1'b1, RES_START},
        {1'b0, 8'h90, 1'b1, RES_ADDR_ACK},   // write bit, no bump
        {1'b0, 8'h00, 1'b1, RES_BYTE0},
        {1'b1, 8'h00, 1'b0, RES_QUIET},      // restart while driving
        {1'b0, 8'h00, 1'b0, RES_QUIET},
        {1'b0, 8'hFF, 1'b0, RES_QUIET}
    };

    // clock and block ports; the driven inputs are known from time zero
    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                in_valid    = 1'b0;
    logic                                in_stall;
    logic                                start_seen  = 1'b0;
    logic [7:0]                          shift_byte  = 8'h00;
    logic                                out_valid;
    logic                                out_stall   = 1'b0;
    logic                                load_shift;
    logic [7:0]                          shift_value;
    logic [3:0]                          bit_count;
    logic                                sda_drive;
    logic                                clear_start;
    logic                                cfg_valid   = 1'b0;
    logic                                cfg_ready;
    logic [i2cst_pkg::CFG_INDEX_W-1:0]   cfg_index   = '0;
    logic [i2cst_pkg::WORD_W-1:0]        cfg_data    = '0;

    // model copy of the registers and sequencer state
    logic [i2cst_pkg::ADDR_W-1:0]        addr_reg    = i2cst_pkg::OWN_ADDRESS_RST;
    logic [i2cst_pkg::WORD_W-1:0]        word_reg    = i2cst_pkg::TX_WORD_RST;
    seq_phase_t                          seq_ph      = SEQ_IDLE;
    logic [i2cst_pkg::IDX_W-1:0]         tx_index    = '0;
    logic [7:0]                          match_addr  = {i2cst_pkg::OWN_ADDRESS_RST, 1'b0};
    logic                                line_driven = 1'b0;

    // commands still owed by the block, oldest first
    i2cst_pkg::result_t                  expected_cmds [$];
    i2cst_pkg::result_t                  oldest_cmd;

    int                                  fails       = 0;
    int                                  cycles      = 0;
    int                                  stall_tick  = 0;
    int                                  stall_mode  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    i2c_slave_transmitter_unit DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_seen  (start_seen),
        .shift_byte  (shift_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .load_shift  (load_shift),
        .shift_value (shift_value),
        .bit_count   (bit_count),
        .sda_drive   (sda_drive),
        .clear_start (clear_start),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------

    // back to idle: line released, compare address reloaded
    function automatic void release_bus();
        line_driven = 1'b0;
        match_addr  = {addr_reg, 1'b0};
        seq_ph      = SEQ_IDLE;
    endfunction

    // next transmit byte, msb byte first, index wraps once past the end
    function automatic void load_next_byte(inout i2cst_pkg::result_t cmd);
        int sh;
        if (tx_index >= i2cst_pkg::BYTES_IDX)
            tx_index = '0;
        sh              = 8 * (3 - int'(tx_index[1:0]));
        line_driven     = 1'b1;
        cmd.load_shift  = 1'b1;
        cmd.shift_value = 8'(word_reg >> sh);
        cmd.bit_count   = i2cst_pkg::CNT_BYTE;
        tx_index        = tx_index + 3'd1;
        seq_ph          = SEQ_ACK_WAIT;
    endfunction

    // command caused by one event beat; advances the model state
    function automatic i2cst_pkg::result_t sequence_event(input logic start,
                                                          input logic [7:0] sb);
        i2cst_pkg::result_t cmd;
        cmd = '0;
        // a start always goes back to address reception
        if (start)
            seq_ph = SEQ_ADDRESS;
        case (seq_ph)
            SEQ_ADDRESS:
            begin
                cmd.bit_count   = i2cst_pkg::CNT_BYTE;
                cmd.clear_start = 1'b1;
                seq_ph          = SEQ_ADDR_CHECK;
            end
            SEQ_ADDR_CHECK:
            begin
                // read bit bumps the stored address first, wrapping in 8 bits
                if (sb[0])
                    match_addr = match_addr + 8'd1;
                line_driven    = 1'b1;
                cmd.load_shift = 1'b1;
                cmd.bit_count  = i2cst_pkg::CNT_ACK;
                if (sb == match_addr)
                begin
                    cmd.shift_value = i2cst_pkg::ACK_BYTE;
                    seq_ph          = SEQ_TX_DATA;
                end
                else
                begin
                    cmd.shift_value = i2cst_pkg::NACK_BYTE;
                    seq_ph          = SEQ_NACK_DONE;
                end
            end
            SEQ_NACK_DONE:
                release_bus();
            SEQ_TX_DATA:
                load_next_byte(cmd);
            SEQ_ACK_WAIT:
            begin
                line_driven   = 1'b0;
                cmd.bit_count = i2cst_pkg::CNT_ACK;
                seq_ph        = SEQ_TX_CHECK;
            end
            SEQ_TX_CHECK:
            begin
                // master nack or no bytes left ends the read
                if (sb[0] || tx_index >= i2cst_pkg::BYTES_IDX)
                begin
                    release_bus();
                    tx_index = '0;
                end
                else
                    load_next_byte(cmd);
            end
            default:
                seq_ph = SEQ_IDLE;
        endcase
        cmd.sda_drive = line_driven;
        return cmd;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one event beat, driven at a falling edge, returns at a falling edge
    task automatic send_event(input logic start, input logic [7:0] sb,
                              input logic typed, input i2cst_pkg::result_t want);
        i2cst_pkg::result_t cmd;
        in_valid   <= 1'b1;
        start_seen <= start;
        shift_byte <= sb;
        do
            @(posedge clk);
        while (in_stall);
        cmd = sequence_event(start, sb);
        // table rows with a typed result override the model's answer
        expected_cmds.push_back(typed ? want : cmd);
        @(negedge clk);
    endtask

    // one register write; the model follows at the accepting edge
    task automatic write_reg(input logic [i2cst_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [i2cst_pkg::WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            i2cst_pkg::REG_OWN_ADDRESS:
            begin
                addr_reg   = data[i2cst_pkg::ADDR_W-1:0];
                match_addr = {data[i2cst_pkg::ADDR_W-1:0], 1'b0};
            end
            i2cst_pkg::REG_TX_WORD:
                word_reg = data;
            default:
                ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // hold until every owed command is in, then let the pipe settle
    task automatic wait_for_results();
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // random event shaped by where the sequencer is, mostly well-formed reads
    task automatic random_events(input int count);
        logic       start;
        logic [7:0] sb;
        int         done;
        int         burst;
        int         pick;
        bit         paused;
        done   = 0;
        paused = 1'b0;
        while (done < count)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && done < count)
            begin
                // idle wants a start, elsewhere a start is a rare restart
                if (seq_ph == SEQ_IDLE || seq_ph == SEQ_NACK_DONE)
                    start = ($urandom_range(0, 9) != 0);
                else
                    start = ($urandom_range(0, 24) == 0);
                sb   = 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                if (seq_ph == SEQ_ADDR_CHECK)
                begin
                    if (pick < 6)
                        sb = match_addr | 8'h01;   // read of this slave
                    else if (pick < 8)
                        sb = match_addr;           // write, or odd address
                end
                else if (seq_ph == SEQ_TX_CHECK)
                    sb[0] = (pick == 0);           // master ack mostly
                // idle beats without a start do nothing, not counted
                if (start || seq_ph != SEQ_IDLE)
                    done++;
                send_event(start, sb, 1'b0, RES_QUIET);
                burst--;
            end
            // sender gaps, once per setting a full drain of the pipe
            if (!paused && done >= count / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                wait_for_results();
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        if (in_valid)
            in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // receiver stall pattern: free, random, periodic and heavy stretches
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= (stall_tick % 5 < 2);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // command checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cmds.size() == 0)
            begin
                $error("command beat with nothing expected");
                fails++;
            end
            else
            begin
                oldest_cmd = expected_cmds.pop_front();
                check_field("load_shift", 8'(oldest_cmd.load_shift), 8'(load_shift));
                check_field("shift_value", oldest_cmd.shift_value, shift_value);
                check_field("bit_count", 8'(oldest_cmd.bit_count), 8'(bit_count));
                check_field("sda_drive", 8'(oldest_cmd.sda_drive), 8'(sda_drive));
                check_field("clear_start", 8'(oldest_cmd.clear_start), 8'(clear_start));
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("i2c_slave_transmitter_unit_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        int set_no;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table with the reset address and a mixed transmit word
        write_reg(i2cst_pkg::REG_TX_WORD, DIR_WORD);
        for (i = 0; i < N_DIRECTED; i++)
        begin
            send_event(DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].sb,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            if ($urandom_range(0, 2) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
        end
        if (in_valid)
            in_valid <= 1'b0;

        // random sequences over several settings, extremes first
        for (set_no = 0; set_no < RANDOM_SETTINGS; set_no++)
        begin
            wait_for_results();
            case (set_no)
                0:
                begin
                    write_reg(i2cst_pkg::REG_OWN_ADDRESS, '0);
                    write_reg(i2cst_pkg::REG_TX_WORD, '0);
                end
                1:
                begin
                    // upper data bits of the address write are dropped
                    write_reg(i2cst_pkg::REG_OWN_ADDRESS, '1);
                    write_reg(i2cst_pkg::REG_TX_WORD, '1);
                end
                2:
                begin
                    write_reg(i2cst_pkg::REG_OWN_ADDRESS,
                              32'(i2cst_pkg::OWN_ADDRESS_RST));
                    write_reg(i2cst_pkg::REG_TX_WORD, $urandom());
                end
                default:
                begin
                    write_reg(i2cst_pkg::REG_OWN_ADDRESS, $urandom());
                    write_reg(i2cst_pkg::REG_TX_WORD, $urandom());
                end
            endcase
            // write past the register list, must leave everything alone
            write_reg(4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom());
            random_events(EVENTS_PER_SET);
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("i2c_slave_transmitter_unit_test: PASS");
        else
            $display("i2c_slave_transmitter_unit_test: FAIL");
        $finish;
    end

endmodule
